// ===== src/slid_pkg.sv =====
package slid_pkg;

    localparam int CAPACITY    = 64;
    localparam int ValueW      = 32;
    localparam int CountW      = $clog2(CAPACITY + 1);
    localparam int EntryCountW = 7;
    localparam int StatusW     = 2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    typedef enum logic [StatusW-1:0] {
        ST_INSERTED  = 2'd0,
        ST_DELETED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // command broadcast to every cell
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic signed [ValueW-1:0] value;
    } cell_cmd_t;

    // what a cell shows its neighbours
    typedef struct packed {
        logic                     valid;
        logic                     lt;
        logic signed [ValueW-1:0] value;
    } cell_link_t;

endpackage

// ===== src/slid_req_if.sv =====
interface slid_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

// ===== src/slid_rsp_if.sv =====
interface slid_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [6:0] entry_count;

    modport source (output valid, output status, output entry_count, input ready);
    modport sink   (input valid, input status, input entry_count, output ready);
endinterface

// ===== src/slid_cell.sv =====
module slid_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  slid_pkg::cell_cmd_t  cmd,
    input  slid_pkg::cell_link_t left,
    input  slid_pkg::cell_link_t right,
    output slid_pkg::cell_link_t link,
    output logic                eq
);
    import slid_pkg::*;

    logic                     valid_reg;
    logic                     valid_next;
    logic signed [ValueW-1:0] value_reg;
    logic signed [ValueW-1:0] value_next;
    logic                     lt;

    assign lt = valid_reg && (value_reg < cmd.value);
    assign eq = valid_reg && (value_reg == cmd.value);

    assign link.valid = valid_reg;
    assign link.lt    = lt;
    assign link.value = value_reg;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (cmd.ins && !lt)
        begin
            // first cell not below the value takes it, the rest shift up
            value_next = left.lt ? cmd.value : left.value;
            valid_next = left.valid;
        end
        else if (cmd.del && !lt)
        begin
            // from the first match onward every cell pulls from the right
            value_next = right.value;
            valid_next = right.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== src/sorted_list_insert_delete.sv =====
// Sorted table of up to 64 signed 32-bit values held in a row of cells, one
// value per cell, in ascending order. Each transfer on req is an insert (mode
// 0) or a delete (mode 1); each gives one transfer on rsp with the status and
// the entry count after the request. On a request transfer every cell
// compares the broadcast value with its own entry at once and shifts with its
// neighbour in the same clock, and the result sits in an output register in
// the cycle after the request transfer. One request per cycle is
// sustained while rsp is ready; the output register is the only buffer, so a
// stalled result holds off the next request. Equal values are kept newest
// first and a delete removes the lowest-placed match.
module sorted_list_insert_delete (
    input logic       clk,
    input logic       rst_n,
    slid_req_if.sink   req,
    slid_rsp_if.source rsp
);
    import slid_pkg::*;

    cell_cmd_t           cmd;
    cell_link_t          link_vec [CAPACITY];
    logic [CAPACITY-1:0] eq_vec;
    logic [CAPACITY-1:0] valid_vec;

    logic [CountW-1:0]   count_reg;
    logic [CountW-1:0]   count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    status_t             status_reg;
    status_t             status_next;
    logic                accept;
    logic                full;
    logic                found;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CountW'(CAPACITY));
    assign found     = |eq_vec;

    assign cmd.value = req.value;
    assign cmd.ins   = accept && (req.mode == MODE_INSERT) && !full;
    assign cmd.del   = accept && (req.mode == MODE_DELETE) && found;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            cell_link_t left_link;
            cell_link_t right_link;

            if (gi == 0)
            begin : g_first
                // the head acts as if an occupied entry below the value sits left of it
                assign left_link.valid = 1'b1;
                assign left_link.lt    = 1'b1;
                assign left_link.value = '0;
            end
            else
            begin : g_left
                assign left_link = link_vec[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_link.valid = 1'b0;
                assign right_link.lt    = 1'b0;
                assign right_link.value = '0;
            end
            else
            begin : g_right
                assign right_link = link_vec[gi+1];
            end

            slid_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cmd),
                .left  (left_link),
                .right (right_link),
                .link  (link_vec[gi]),
                .eq    (eq_vec[gi])
            );

            assign valid_vec[gi] = link_vec[gi].valid;
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        if (rsp.ready)
            out_valid_next = 1'b0;
        if (accept)
        begin
            out_valid_next = 1'b1;
            if (req.mode == MODE_INSERT)
            begin
                if (full)
                    status_next = ST_FULL;
                else
                begin
                    status_next = ST_INSERTED;
                    count_next  = count_reg + CountW'(1);
                end
            end
            else
            begin
                if (found)
                begin
                    status_next = ST_DELETED;
                    count_next  = count_reg - CountW'(1);
                end
                else
                    status_next = ST_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.entry_count = EntryCountW'(count_reg);

    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == 32'(count_reg))
        else $error("occupied cells disagree with the entry count");

    a_result_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("request transfer gave no result");

    a_full_only_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_FULL) |-> full)
        else $error("full status while the table has room");

    a_no_take_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |-> !accept)
        else $error("request taken while a result is stalled");

    a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.del |=> (count_reg == $past(count_reg) - CountW'(1)))
        else $error("delete did not lower the count");

endmodule

// ===== verif/tb_sorted_list_insert_delete.sv =====
module tb_sorted_list_insert_delete;
    import slid_pkg::*;

    localparam int WatchdogLimit = 500;
    localparam int RandomItems   = 2000;
    localparam int CalmTail      = 200;
    localparam int SettleCycles  = 20;

    typedef struct packed {
        status_t                status;
        logic [EntryCountW-1:0] count;
    } table_result_t;

    // mirror of the table, ascending, plus the results still owed by the block
    class sorted_table_tracker;
        logic signed [ValueW-1:0] entries[$];
        table_result_t            due_results[$];
        int unsigned              mismatches;
        int unsigned              status_tally[4];
        int unsigned              fills;
        int unsigned              empties;

        function void apply_request(logic mode, logic [ValueW-1:0] raw);
            logic signed [ValueW-1:0] v;
            int                       pos;
            table_result_t            r;
            v   = raw;
            pos = 0;
            if (mode == MODE_INSERT)
            begin
                if (entries.size() >= CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // equal values go in front of the older ones
                    while (pos < entries.size() && entries[pos] < v)
                        pos++;
                    entries.insert(pos, v);
                    r.status = ST_INSERTED;
                    if (entries.size() == CAPACITY)
                        fills++;
                end
            end
            else
            begin
                while (pos < entries.size() && entries[pos] != v)
                    pos++;
                if (pos >= entries.size())
                begin
                    r.status = ST_NOT_FOUND;
                end
                else
                begin
                    entries.delete(pos);
                    r.status = ST_DELETED;
                    if (entries.size() == 0)
                        empties++;
                end
            end
            r.count = EntryCountW'(entries.size());
            status_tally[r.status]++;
            due_results.push_back(r);
        endfunction

        function void check_response(logic [StatusW-1:0] status,
                                     logic [EntryCountW-1:0] count);
            table_result_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t: result with nothing outstanding: status %0d count %0d",
                         $time, status, count);
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, status);
                    mismatches++;
                end
                if (count !== want.count)
                begin
                    $display("%0t: entry count mismatch: expected %0d actual %0d",
                             $time, want.count, count);
                    mismatches++;
                end
            end
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        function int occupancy();
            return entries.size();
        endfunction

        function logic [ValueW-1:0] pick_stored();
            if (entries.size() == 0)
                return $urandom;
            return entries[$urandom_range(0, entries.size() - 1)];
        endfunction
    endclass

    logic clk;
    logic rst_n;

    slid_req_if req_bus ();
    slid_rsp_if rsp_bus ();

    sorted_table_tracker tracker;

    bit          sender_idling;
    bit          receiver_idling;
    int          rsp_hold_len;
    int          quiet_cycles;
    int unsigned sent;

    sorted_list_insert_delete uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // transfers are sampled here, results checked before new requests are noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_bus.valid && rsp_bus.ready)
                tracker.check_response(rsp_bus.status, rsp_bus.entry_count);
            if (req_bus.valid && req_bus.ready)
                tracker.apply_request(req_bus.mode, req_bus.value);
            if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles + 1 >= WatchdogLimit)
            begin
                $display("%0t: no transfer for %0d cycles", $time, WatchdogLimit);
                $display("TEST FAILED");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // result side: random back-pressure bursts and the occasional long hold-off
    initial
    begin
        rsp_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rsp_hold_len > 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (rsp_hold_len) @(negedge clk);
                rsp_hold_len = 0;
                rsp_bus.ready <= 1'b1;
            end
            else if (receiver_idling && $urandom_range(0, 5) == 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                rsp_bus.ready <= 1'b1;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_request(input logic mode, input logic [ValueW-1:0] value);
        if (sender_idling && $urandom_range(0, 5) == 0)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.mode  <= mode;
        req_bus.value <= value;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        req_bus.valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(negedge clk);
    endtask

    // mostly a small pool so that duplicates and hits are common
    function automatic logic [ValueW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    default: return 32'h8000_0001;
                endcase
            end
            1, 2:    return $urandom;
            default: return 32'(int'($urandom_range(0, 15)) - 8);
        endcase
    endfunction

    initial
    begin
        bit filling;
        bit add;
        tracker         = new;
        sent            = 0;
        quiet_cycles    = 0;
        rsp_hold_len    = 0;
        sender_idling   = 1'b1;
        receiver_idling = 1'b1;
        rst_n           = 1'b0;
        req_bus.valid   = 1'b0;
        req_bus.mode    = MODE_INSERT;
        req_bus.value   = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // delete on an empty table
        send_request(MODE_DELETE, 32'h0000_0000);
        send_request(MODE_INSERT, 32'h7FFF_FFFF);
        send_request(MODE_INSERT, 32'h8000_0000);
        send_request(MODE_INSERT, 32'h0000_0000);
        send_request(MODE_INSERT, 32'hFFFF_FFFF);
        send_request(MODE_INSERT, 32'h0000_0001);
        send_request(MODE_INSERT, 32'h0000_0005);
        send_request(MODE_INSERT, 32'h0000_0005);
        send_request(MODE_INSERT, 32'hAAAA_AAAA);
        send_request(MODE_INSERT, 32'h5555_5555);
        // one of the two duplicates only
        send_request(MODE_DELETE, 32'h0000_0005);
        send_request(MODE_DELETE, 32'h0000_0007);
        send_request(MODE_DELETE, 32'h8000_0000);
        send_request(MODE_DELETE, 32'h7FFF_FFFF);
        send_request(MODE_DELETE, 32'h7FFF_FFFF);
        send_request(MODE_DELETE, 32'h0000_0005);
        send_request(MODE_DELETE, 32'hAAAA_AAAA);
        send_request(MODE_DELETE, 32'h5555_5555);
        send_request(MODE_DELETE, 32'h0000_0000);
        send_request(MODE_DELETE, 32'hFFFF_FFFF);
        send_request(MODE_DELETE, 32'h0000_0001);
        send_request(MODE_DELETE, 32'h0000_0001);
        wait_for_drain();

        // swing between filling past full and draining past empty
        filling = 1'b1;
        for (int i = 0; i < RandomItems; i++)
        begin
            if (i % 150 == 0)
            begin
                sender_idling   = (i < RandomItems - CalmTail) && ($urandom_range(0, 2) != 0);
                receiver_idling = (i < RandomItems - CalmTail) && ($urandom_range(0, 2) != 0);
            end
            if (i % 400 == 100 && i < RandomItems - CalmTail)
            begin
                // block fills up behind a stalled receiver
                rsp_hold_len  = $urandom_range(30, 60);
                sender_idling = 1'b0;
            end
            if (i % 400 == 350)
                wait_for_drain();
            if (filling && tracker.occupancy() == CAPACITY && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (!filling && tracker.occupancy() == 0 && $urandom_range(0, 3) == 0)
                filling = 1'b1;
            add = filling ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 99) < 15);
            if (add)
                send_request(MODE_INSERT, pick_value());
            else if ($urandom_range(0, 3) != 0)
                send_request(MODE_DELETE, tracker.pick_stored());
            else
                send_request(MODE_DELETE, pick_value());
        end

        wait_for_drain();
        repeat (SettleCycles) @(negedge clk);

        $display("%0d requests: %0d inserted, %0d deleted, %0d not found, %0d refused as full",
                 sent, tracker.status_tally[ST_INSERTED], tracker.status_tally[ST_DELETED],
                 tracker.status_tally[ST_NOT_FOUND], tracker.status_tally[ST_FULL]);
        $display("table reached full %0d times and emptied %0d times, %0d mismatches",
                 tracker.fills, tracker.empties, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
